@@ hdl/srrf_pkg.sv @@
// Shared types and constants for the score run region finder.
package srrf_pkg;

  localparam int PIECE_MAX_DEF = 16384;

  localparam int SCORE_W    = 16;
  localparam int ROW_W      = 14;
  localparam int LO_W       = 14;
  localparam int HI_W       = 15;
  localparam int GAP_W      = 16;
  localparam int FIRST_W    = 16;
  localparam int LAST_W     = 17;
  localparam int OV_W       = 15;
  localparam int MGAP_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_ANTIDIAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTIDIAG_CNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SHORT_GAP,
    ST_LONG_GAP
  } run_state_t;

  typedef struct packed {
    logic [LO_W-1:0] lo;
    logic [HI_W-1:0] hi;
    logic            last;
  } interval_t;

endpackage

@@ hdl/srrf_interval.sv @@
// Widens a finished run by the overlap, clamps it to the region and maps it to row/column.
module srrf_interval import srrf_pkg::*; #(
  parameter int DW = 16
) (
  input  logic [DW-1:0]            run_begin,
  input  logic signed [DW:0]       run_finish,
  input  logic [FIRST_W-1:0]       first_diag,
  input  logic signed [LAST_W-1:0] last_diag,
  input  logic signed [OV_W-1:0]   overlap,
  input  logic [ROW_W-1:0]         cur_antidiag,
  output logic [LO_W-1:0]          interval_low,
  output logic [HI_W-1:0]          interval_high
);

  localparam int AW = DW + 3;
  localparam logic signed [AW-1:0] ONE_S    = AW'(1);
  localparam logic signed [AW-1:0] ZERO_S   = AW'(0);
  localparam logic signed [AW-1:0] LO_MAX_S = AW'((1 << LO_W) - 1);
  localparam logic signed [AW-1:0] HI_MAX_S = AW'((1 << HI_W) - 1);

  logic signed [AW-1:0] beg_s, fin_s, first_s, last_s, ov_s, cur_s;
  logic signed [AW-1:0] b_w, f_w, x_lo, x_hi, rnd_s, sum_s, q_lo, h_w, hi_w;

  always_comb begin
    beg_s   = AW'({1'b0, run_begin});
    fin_s   = AW'(run_finish);
    first_s = AW'({1'b0, first_diag});
    last_s  = AW'(last_diag);
    ov_s    = AW'(overlap);
    cur_s   = AW'({1'b0, cur_antidiag});

    b_w = beg_s - ov_s;
    if (b_w < first_s) b_w = first_s;
    f_w = fin_s + ov_s;
    if (f_w > last_s) f_w = last_s;

    x_lo = b_w - cur_s;
    q_lo = x_lo >>> 1;
    if (x_lo < ZERO_S) begin
      interval_low = '0;
    end else if (q_lo > LO_MAX_S) begin
      interval_low = LO_MAX_S[LO_W-1:0];
    end else begin
      interval_low = q_lo[LO_W-1:0];
    end

    // the arithmetic shift rounds down, so bias negatives by one to halve toward zero
    x_hi  = f_w - cur_s - ONE_S;
    rnd_s = x_hi[AW-1] ? ONE_S : ZERO_S;
    sum_s = x_hi + rnd_s;
    h_w   = sum_s >>> 1;
    hi_w  = h_w + cur_s;
    if (hi_w < ZERO_S) begin
      interval_high = '0;
    end else if (hi_w > HI_MAX_S) begin
      interval_high = HI_MAX_S[HI_W-1:0];
    end else begin
      interval_high = hi_w[HI_W-1:0];
    end
  end

endmodule

@@ hdl/srrf_outq.sv @@
// Four-entry result queue; takes up to two intervals per cycle, gives one.
module srrf_outq import srrf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push0,
  input  logic      push1,
  input  interval_t din0,
  input  interval_t din1,
  input  logic      pop,
  output interval_t dout,
  output logic      not_empty,
  output logic      room2
);

  localparam int QD = 4;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  interval_t       q_r [QD];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]   cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push0) + PW'(push1);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push0) + CW'(push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) q_r[wr_ptr_r] <= din0;
    if (push1) q_r[wr_ptr_r + PW'(1)] <= din1;
  end

  assign dout      = q_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= CW'(QD - 2));

endmodule

@@ hdl/score_run_region_finder_core.sv @@
// Score run region finder: diagonal scores in, widened run intervals out. One item is
// taken per cycle while in_stall is low. An accepted item sits in the input register,
// where the run state machine and both interval units evaluate it, and its zero, one or
// two intervals are written into a four-entry result queue that feeds the out_ port. An
// item leaves the input register only when the queue has two free entries, so in_stall
// rises when intervals are produced faster than the output side takes them. With an empty
// queue, an item's first interval passes the input register and the result queue before
// it is offered on out_. Configuration registers feed the evaluation logic directly.
module score_run_region_finder_core import srrf_pkg::*; #(
  parameter int PIECE_MAX = PIECE_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic                   in_region_first,
  input  logic                   in_region_final,
  input  logic [ROW_W-1:0]       in_region_low,
  input  logic [ROW_W-1:0]       in_region_high,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LO_W-1:0]        out_interval_low,
  output logic [HI_W-1:0]        out_interval_high,
  output logic                   out_last_of_item
);

  localparam int DW = ($clog2(4 * PIECE_MAX) > FIRST_W) ? $clog2(4 * PIECE_MAX) : FIRST_W;
  localparam logic [DW-1:0] DIAG_SAT = DW'(4 * PIECE_MAX - 1);

  // configuration
  logic signed [SCORE_W-1:0] thr_r;
  logic [ROW_W-1:0]          cur_r, adc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      cur_r <= '0;
      adc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:    thr_r <= cfg_wdata[SCORE_W-1:0];
        CFG_CUR_ANTIDIAG: cur_r <= cfg_wdata[ROW_W-1:0];
        CFG_ANTIDIAG_CNT: adc_r <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [OV_W-1:0]   overlap;
  logic signed [MGAP_W-1:0] ov_ext, min_gap;

  assign overlap = $signed({1'b0, adc_r}) - $signed({1'b0, cur_r});
  assign ov_ext  = MGAP_W'(overlap);
  assign min_gap = ov_ext + (ov_ext <<< 1);

  // input register
  logic                      p_vld_r, p_first_r, p_final_r;
  logic signed [SCORE_W-1:0] p_score_r;
  logic [ROW_W-1:0]          p_low_r, p_high_r;
  logic                      adv, take, q_room;

  assign adv      = p_vld_r && q_room;
  assign in_stall = p_vld_r && !q_room;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (take) begin
      p_vld_r <= 1'b1;
    end else if (adv) begin
      p_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_score_r <= in_score;
      p_first_r <= in_region_first;
      p_final_r <= in_region_final;
      p_low_r   <= in_region_low;
      p_high_r  <= in_region_high;
    end
  end

  // run state
  run_state_t               state_r, state_nxt, state_cur;
  logic [GAP_W-1:0]         gap_r, gap_nxt;
  logic [DW-1:0]            begin_r, begin_nxt;
  logic signed [DW:0]       finish_r, finish_nxt;
  logic [DW-1:0]            diag_r, diag_nxt;
  logic [FIRST_W-1:0]       first_r, first_nxt;
  logic signed [LAST_W-1:0] last_r, last_nxt;
  logic                     hit, emit_a, emit_b;

  always_comb begin
    state_cur  = state_r;
    gap_nxt    = gap_r;
    begin_nxt  = begin_r;
    finish_nxt = finish_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    emit_a     = 1'b0;
    emit_b     = 1'b0;

    if (p_first_r) begin
      first_nxt  = {2'b00, cur_r} + {1'b0, p_low_r, 1'b0};
      last_nxt   = $signed({2'b00, p_high_r, 1'b0} + 17'd2 - {3'b000, cur_r});
      state_cur  = ST_IDLE;
      begin_nxt  = DW'(first_nxt);
      finish_nxt = (DW + 1)'(last_nxt);
      gap_nxt    = '0;
      diag_nxt   = DW'(first_nxt);
    end else if (diag_r >= DIAG_SAT) begin
      diag_nxt = DIAG_SAT;
    end else begin
      diag_nxt = diag_r + DW'(1);
    end

    hit       = (p_score_r >= thr_r);
    state_nxt = state_cur;

    case (state_cur)
      ST_IDLE: begin
        if (hit) begin
          begin_nxt = diag_nxt;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!hit) begin
          finish_nxt = $signed({1'b0, diag_nxt - DW'(1)});
          gap_nxt    = GAP_W'(1);
          state_nxt  = ST_SHORT_GAP;
        end
      end
      ST_SHORT_GAP: begin
        if (!hit) begin
          if (gap_nxt != '1) gap_nxt = gap_nxt + GAP_W'(1);
          if ($signed({1'b0, gap_nxt}) == min_gap) state_nxt = ST_LONG_GAP;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_LONG_GAP: begin
        // previous run closes on the old begin/finish, new run opens here
        if (hit) begin
          emit_a    = 1'b1;
          begin_nxt = diag_nxt;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (p_final_r) begin
      if (state_nxt != ST_IDLE) begin
        if (state_nxt == ST_RUN) finish_nxt = (DW + 1)'(last_nxt);
        emit_b = 1'b1;
      end
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      gap_r    <= '0;
      begin_r  <= '0;
      finish_r <= '0;
      diag_r   <= '0;
      first_r  <= '0;
      last_r   <= '0;
    end else if (adv) begin
      state_r  <= state_nxt;
      gap_r    <= gap_nxt;
      begin_r  <= begin_nxt;
      finish_r <= finish_nxt;
      diag_r   <= diag_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
    end
  end

  // interval mapping
  logic [LO_W-1:0] a_lo, b_lo;
  logic [HI_W-1:0] a_hi, b_hi;

  srrf_interval #(.DW(DW)) u_iv_a (
    .run_begin     (begin_r),
    .run_finish    (finish_r),
    .first_diag    (first_nxt),
    .last_diag     (last_nxt),
    .overlap       (overlap),
    .cur_antidiag  (cur_r),
    .interval_low  (a_lo),
    .interval_high (a_hi)
  );

  srrf_interval #(.DW(DW)) u_iv_b (
    .run_begin     (begin_nxt),
    .run_finish    (finish_nxt),
    .first_diag    (first_nxt),
    .last_diag     (last_nxt),
    .overlap       (overlap),
    .cur_antidiag  (cur_r),
    .interval_low  (b_lo),
    .interval_high (b_hi)
  );

  interval_t res0, res1, head;
  logic      push0, push1, q_nonempty, pop;

  always_comb begin
    res1.lo   = b_lo;
    res1.hi   = b_hi;
    res1.last = 1'b1;
    if (emit_a) begin
      res0.lo   = a_lo;
      res0.hi   = a_hi;
      res0.last = !emit_b;
    end else begin
      res0 = res1;
    end
  end

  assign push0 = adv && (emit_a || emit_b);
  assign push1 = adv && emit_a && emit_b;
  assign pop   = q_nonempty && !out_stall;

  srrf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .din0      (res0),
    .din1      (res1),
    .pop       (pop),
    .dout      (head),
    .not_empty (q_nonempty),
    .room2     (q_room)
  );

  assign out_valid         = q_nonempty;
  assign out_interval_low  = head.lo;
  assign out_interval_high = head.hi;
  assign out_last_of_item  = head.last;

endmodule

@@ hdl/srrf_checker.sv @@
// Port-level checks for the score run region finder, bound to the top level.
module srrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_interval_low,
  input logic [14:0] out_interval_high,
  input logic        out_last_of_item
);

  // a waiting interval stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_interval_low)
      && $stable(out_interval_high) && $stable(out_last_of_item))
    else $error("out item changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not quiet after reset");

  // the input side only stalls on a nearly full result queue
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // a stall can only start right after an item was taken
  a_stall_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall rose without a preceding item");

endmodule

bind score_run_region_finder_core srrf_checker u_srrf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_interval_low  (out_interval_low),
  .out_interval_high (out_interval_high),
  .out_last_of_item  (out_last_of_item)
);
